/* rtl/quoted_argument_tokenizer_unit_defines.svh */
// assertion macros shared by the tokenizer rtl
// expects clk and rst in the scope of the module that uses them
`ifndef QUOTED_ARGUMENT_TOKENIZER_UNIT_DEFINES_SVH
`define QUOTED_ARGUMENT_TOKENIZER_UNIT_DEFINES_SVH

// property must hold at every edge outside reset
`define QATU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define QATU_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/qatu_pkg.sv */
// shared types and constants of the quoted argument tokenizer
// no dependencies
package qatu_pkg;

  // parse modes of the front end
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_UNQ     = 4'd1,
    MODE_DQ      = 4'd2,
    MODE_DQ_ESC  = 4'd3,
    MODE_DQ_X    = 4'd4,
    MODE_DQ_XH   = 4'd5,
    MODE_SQ      = 4'd6,
    MODE_SQ_ESC  = 4'd7,
    MODE_CLOSE   = 4'd8,
    MODE_DISCARD = 4'd9
  } mode_t;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LX     = 8'h78;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // stream widths
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned M_TUSER_W = 4;

  // results per input character
  localparam int unsigned MAX_ITEMS  = 3;
  localparam int unsigned ITEM_IDX_W = 2;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       arg_end;
    logic       line_done;
    logic       parse_error;
    logic [7:0] arg_count;
  } item_t;

  // all results caused by one character
  typedef struct packed {
    logic [ITEM_IDX_W-1:0]        num;
    item_t [MAX_ITEMS-1:0]        items;
  } bundle_t;

  // front to queue
  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } push_t;

  // queue to back
  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } head_t;

endpackage

/* rtl/qatu_front.sv */
// front end: accepts characters, runs the parse mode machine and builds result bundles
// depends on qatu_pkg
module qatu_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [qatu_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] char_code
  input  logic                            full,
  output qatu_pkg::push_t                 wr
);
  import qatu_pkg::*;

  mode_t      mode, mode_next;
  logic [7:0] held_hex_char, held_next;
  logic [7:0] completed_args, cnt_next;
  logic [7:0] c;
  logic       accept;
  bundle_t    bnd;
  logic       c_hex;
  logic       run_dq, run_sq, run_unq;

  assign c        = s_tdata;
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  endfunction

  function automatic logic is_sep(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_LF) || (ch == CH_CR) || (ch == CH_TAB);
  endfunction

  function automatic logic is_hex(input logic [7:0] ch);
    return ((ch >= 8'h30) && (ch <= 8'h39)) || ((ch >= 8'h61) && (ch <= 8'h66)) ||
           ((ch >= 8'h41) && (ch <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    logic [7:0] v;
    v = 8'h00;
    if ((ch >= 8'h30) && (ch <= 8'h39)) v = ch - 8'h30;
    else if ((ch >= 8'h61) && (ch <= 8'h66)) v = ch - 8'h57;
    else if ((ch >= 8'h41) && (ch <= 8'h46)) v = ch - 8'h37;
    return v[3:0];
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] ch);
    logic [7:0] r;
    case (ch)
      CH_LA:   r = CH_BEL;
      CH_LB:   r = CH_BS;
      CH_LN:   r = CH_LF;
      CH_LR:   r = CH_CR;
      CH_LT:   r = CH_TAB;
      default: r = ch;
    endcase
    return r;
  endfunction

  // append one result to a bundle
  function automatic bundle_t add(input bundle_t b, input logic [7:0] by, input logic bv,
                                  input logic ae, input logic ld, input logic pe,
                                  input logic [7:0] cnt);
    bundle_t r;
    item_t   it;
    r              = b;
    it.out_byte    = bv ? by : 8'h00;
    it.byte_valid  = bv;
    it.arg_end     = ae;
    it.line_done   = ld;
    it.parse_error = pe;
    it.arg_count   = cnt;
    r.items[b.num] = it;
    r.num          = b.num + 1'b1;
    return r;
  endfunction

  function automatic mode_t dq_next(input logic [7:0] ch);
    mode_t m;
    if (ch == CH_BSLASH) m = MODE_DQ_ESC;
    else if (ch == CH_DQUOTE) m = MODE_CLOSE;
    else if (ch == CH_NUL) m = MODE_IDLE;
    else m = MODE_DQ;
    return m;
  endfunction

  function automatic mode_t sq_next(input logic [7:0] ch);
    mode_t m;
    if (ch == CH_BSLASH) m = MODE_SQ_ESC;
    else if (ch == CH_SQUOTE) m = MODE_CLOSE;
    else if (ch == CH_NUL) m = MODE_IDLE;
    else m = MODE_SQ;
    return m;
  endfunction

  function automatic mode_t unq_next(input logic [7:0] ch);
    mode_t m;
    if ((ch == CH_NUL) || is_sep(ch)) m = MODE_IDLE;
    else if (ch == CH_DQUOTE) m = MODE_DQ;
    else if (ch == CH_SQUOTE) m = MODE_SQ;
    else m = MODE_UNQ;
    return m;
  endfunction

  assign c_hex = is_hex(c);

  // next parse mode
  always_comb begin
    unique case (mode)
      MODE_UNQ:     mode_next = unq_next(c);
      MODE_DQ:      mode_next = dq_next(c);
      MODE_DQ_ESC: begin
        if (c == CH_LX) mode_next = MODE_DQ_X;
        else if (c == CH_NUL) mode_next = MODE_IDLE;
        else mode_next = MODE_DQ;
      end
      MODE_DQ_X:    mode_next = c_hex ? MODE_DQ_XH : dq_next(c);
      MODE_DQ_XH:   mode_next = c_hex ? MODE_DQ : dq_next(c);
      MODE_SQ:      mode_next = sq_next(c);
      MODE_SQ_ESC:  mode_next = (c == CH_SQUOTE) ? MODE_SQ : sq_next(c);
      MODE_CLOSE: begin
        if ((c == CH_NUL) || is_ws(c)) mode_next = MODE_IDLE;
        else mode_next = MODE_DISCARD;
      end
      MODE_DISCARD: mode_next = (c == CH_NUL) ? MODE_IDLE : MODE_DISCARD;
      default: begin
        if ((c == CH_NUL) || is_ws(c)) mode_next = MODE_IDLE;
        else mode_next = unq_next(c);
      end
    endcase
  end

  // results, held hex digit and argument count
  always_comb begin
    bnd       = '0;
    cnt_next  = completed_args;
    held_next = held_hex_char;
    run_dq    = 1'b0;
    run_sq    = 1'b0;
    run_unq   = 1'b0;
    unique case (mode)
      MODE_UNQ: run_unq = 1'b1;
      MODE_DQ:  run_dq  = 1'b1;
      MODE_DQ_ESC: begin
        if (c == CH_NUL) begin
          bnd      = add(bnd, CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0, cnt_next);
          bnd      = add(bnd, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b1, cnt_next);
          cnt_next = '0;
        end else if (c != CH_LX) begin
          bnd = add(bnd, esc_map(c), 1'b1, 1'b0, 1'b0, 1'b0, cnt_next);
        end
      end
      MODE_DQ_X: begin
        if (c_hex) begin
          held_next = c;
        end else begin
          bnd    = add(bnd, CH_LX, 1'b1, 1'b0, 1'b0, 1'b0, cnt_next);
          run_dq = 1'b1;
        end
      end
      MODE_DQ_XH: begin
        if (c_hex) begin
          bnd = add(bnd, {hex_val(held_hex_char), hex_val(c)}, 1'b1, 1'b0, 1'b0, 1'b0,
                    cnt_next);
        end else begin
          bnd    = add(bnd, CH_LX, 1'b1, 1'b0, 1'b0, 1'b0, cnt_next);
          bnd    = add(bnd, held_hex_char, 1'b1, 1'b0, 1'b0, 1'b0, cnt_next);
          run_dq = 1'b1;
        end
      end
      MODE_SQ: run_sq = 1'b1;
      MODE_SQ_ESC: begin
        if (c == CH_SQUOTE) begin
          bnd = add(bnd, CH_SQUOTE, 1'b1, 1'b0, 1'b0, 1'b0, cnt_next);
        end else begin
          bnd    = add(bnd, CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0, cnt_next);
          run_sq = 1'b1;
        end
      end
      MODE_CLOSE: begin
        if ((c == CH_NUL) || is_ws(c)) begin
          if (cnt_next != COUNT_MAX) cnt_next = cnt_next + 8'd1;
          bnd = add(bnd, CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0, cnt_next);
          if (c == CH_NUL) begin
            bnd      = add(bnd, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0, cnt_next);
            cnt_next = '0;
          end
        end else begin
          bnd = add(bnd, CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1, cnt_next);
        end
      end
      MODE_DISCARD: begin
        if (c == CH_NUL) begin
          bnd      = add(bnd, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b1, cnt_next);
          cnt_next = '0;
        end
      end
      default: begin
        if (c == CH_NUL) begin
          bnd      = add(bnd, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0, cnt_next);
          cnt_next = '0;
        end else if (!is_ws(c)) begin
          run_unq = 1'b1;
        end
      end
    endcase

    // character handling shared by several modes, after any prefix bytes
    if (run_dq || run_sq) begin
      if (c == CH_NUL) begin
        bnd      = add(bnd, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b1, cnt_next);
        cnt_next = '0;
      end else if ((c != CH_BSLASH) && !(run_dq && (c == CH_DQUOTE)) &&
                   !(run_sq && (c == CH_SQUOTE))) begin
        bnd = add(bnd, c, 1'b1, 1'b0, 1'b0, 1'b0, cnt_next);
      end
    end
    if (run_unq) begin
      if ((c == CH_NUL) || is_sep(c)) begin
        if (cnt_next != COUNT_MAX) cnt_next = cnt_next + 8'd1;
        bnd = add(bnd, CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0, cnt_next);
        if (c == CH_NUL) begin
          bnd      = add(bnd, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0, cnt_next);
          cnt_next = '0;
        end
      end else if ((c != CH_DQUOTE) && (c != CH_SQUOTE)) begin
        bnd = add(bnd, c, 1'b1, 1'b0, 1'b0, 1'b0, cnt_next);
      end
    end
  end

  assign wr.valid  = accept && (bnd.num != '0);
  assign wr.bundle = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      held_hex_char  <= '0;
      completed_args <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      held_hex_char  <= held_next;
      completed_args <= cnt_next;
    end
  end

endmodule

/* rtl/qatu_queue.sv */
// short queue of result bundles between front and back end
// depends on qatu_pkg and the assertion macro header
module qatu_queue (
  input  logic            clk,
  input  logic            rst,
  input  qatu_pkg::push_t wr,
  input  logic            pop,
  output logic            full,
  output qatu_pkg::head_t head
);
  import qatu_pkg::*;
  `include "quoted_argument_tokenizer_unit_defines.svh"

  bundle_t             slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full        = (count == QCNT_W'(QDEPTH));
  assign head.valid  = (count != '0);
  assign head.bundle = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.valid) slots[wr_ptr] <= wr.bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop)      rd_ptr <= rd_ptr + 1'b1;
      case ({wr.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `QATU_NEVER(a_q_no_overflow, wr.valid && full && !pop, "bundle pushed into full queue")
  `QATU_NEVER(a_q_no_underflow, pop && !head.valid, "pop from empty queue")

endmodule

/* rtl/qatu_back.sv */
// back end: walks the head bundle, one item per cycle unless stalled, into the output register
// depends on qatu_pkg and the assertion macro header
module qatu_back (
  input  logic                            clk,
  input  logic                            rst,
  input  qatu_pkg::head_t                 head,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [qatu_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [15:8] arg_count
  output logic [qatu_pkg::M_TUSER_W-1:0]  m_tuser,   // byte_valid, arg_end, line_done, parse_error
  output logic                            m_tlast
);
  import qatu_pkg::*;
  `include "quoted_argument_tokenizer_unit_defines.svh"

  logic [ITEM_IDX_W-1:0] sel;
  logic                  load;
  logic                  last;
  item_t                 cur;

  assign load = head.valid && (!m_tvalid || m_tready);
  assign cur  = head.bundle.items[sel];
  assign last = (sel == (head.bundle.num - 1'b1));
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sel      <= '0;
    end else begin
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (load) sel <= last ? '0 : sel + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {cur.arg_count, cur.out_byte};
      m_tuser <= {cur.parse_error, cur.line_done, cur.arg_end, cur.byte_valid};
      m_tlast <= last;
    end
  end

  `QATU_ASSERT(a_back_sel_in_bundle, head.valid |-> (sel < head.bundle.num), "item index past bundle")
  `QATU_ASSERT(a_back_one_kind, m_tvalid |-> $onehot0(m_tuser[2:0]), "item carries several kinds")
  `QATU_ASSERT(a_back_line_last, (m_tvalid && m_tuser[2]) |-> m_tlast, "line end not last of run")

endmodule

/* rtl/quoted_argument_tokenizer_unit.sv */
// Shell-style argument splitter. One line character is taken per cycle on the s_ stream
// (a zero byte ends the line); the m_ stream returns argument bytes, end-of-argument
// markers, one end-of-line marker per line and error markers for unterminated quotes or
// a bad closing quote, after which the rest of the line is dropped. Each character gives
// zero to three result items; m_tlast flags the final item caused by a character. A
// character is accepted every cycle while the four-entry bundle queue between the parser
// and the output stage has room, with no wait on the output side. The output stage sends
// one item per cycle while m_tready is high, so sustained throughput is one character
// per cycle as long as characters average at most one result item, and otherwise is set
// by the total item count at one item per cycle. The items of an accepted character are
// queued as a bundle, then registered for output. There is no clearing pass after reset.
// Holds the top level; depends on qatu_pkg, qatu_front, qatu_queue and qatu_back.
module quoted_argument_tokenizer_unit (
  input  logic                            clk,
  input  logic                            rst,
  // character input
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [qatu_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] char_code
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [qatu_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [15:8] arg_count
  output logic [qatu_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] byte_valid, [1] arg_end,
                                                     // [2] line_done, [3] parse_error
  output logic                            m_tlast    // last_of_run
);
  import qatu_pkg::*;

  push_t wr;     // bundle from the parser, valid only when it holds items
  head_t head;   // oldest queued bundle
  logic  full;
  logic  pop;

  // parser: mode machine, held hex digit and saturating argument count
  qatu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .full     (full),
    .wr       (wr)
  );

  // decouples parsing from output backpressure
  qatu_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  // serializes each bundle into items, one per cycle unless the output is stalled
  qatu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* test/quoted_argument_tokenizer_unit_test.sv */
// self-checking testbench of quoted_argument_tokenizer_unit: characters go in on the s_ stream,
// result items come back on the m_ stream and are checked against a behavioral tokenizer here
// depends on qatu_pkg and quoted_argument_tokenizer_unit
`timescale 1ns / 100ps

module quoted_argument_tokenizer_unit_test;
  import qatu_pkg::*;

  // extra character codes used by the tokenizer model, the line generator and the directed lines
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FFEED = 8'h0C;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_LOWF  = 8'h66;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPF   = 8'h46;
  localparam logic [7:0] CH_TOP   = 8'hFF;

  localparam int RAND_ITEMS = 245;
  localparam int HOLD_LEN   = 200;     // long receiver hold-off, in cycles
  localparam int LIMIT      = 1000000; // cycle limit of the whole run

  // one result item as seen on the m_ stream
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       arg_end;
    logic       line_done;
    logic       parse_error;
    logic [7:0] arg_count;
    logic       last;
  } result_t;

  // directed row: a character, and where typed is set, the single result it must give
  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    result_t    res;
  } dir_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  m_tlast;

  // tokenizer model state
  mode_t      tok_mode = MODE_IDLE;
  logic [7:0] hex_first = 8'h00;
  logic [7:0] arg_total = 8'h00;

  result_t    step_q[$];     // items caused by the character being predicted
  result_t    pending_q[$];  // items still owed by the block, oldest first
  logic [7:0] line_q[$];     // characters of the generated line
  dir_row_t   dir_tab[25];

  int fail_count   = 0;
  int results_seen = 0;
  int send_idle_pct = 0;

  quoted_argument_tokenizer_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------------
  // tokenizer model
  // ---------------------------------------------------------------------------------------------

  // space, tab, newline, vertical tab, form feed, carriage return
  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_hexdig(logic [7:0] c);
    return (c >= CH_DIG0 && c <= CH_DIG9) || (c >= CH_LA && c <= CH_LOWF)
        || (c >= CH_UPA && c <= CH_UPF);
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    if (c >= CH_DIG0 && c <= CH_DIG9) return 4'(c - CH_DIG0);
    if (c >= CH_LA && c <= CH_LOWF) return 4'(c - CH_LA + 8'd10);
    return 4'(c - CH_UPA + 8'd10);
  endfunction

  // letter after a backslash inside double quotes
  function automatic logic [7:0] esc_byte(logic [7:0] c);
    case (c)
      CH_LA:   return CH_BEL;
      CH_LB:   return CH_BS;
      CH_LN:   return CH_LF;
      CH_LR:   return CH_CR;
      CH_LT:   return CH_TAB;
      default: return c;
    endcase
  endfunction

  // arg_count always carries the count after any completion in this item
  function automatic void add_result(logic [7:0] b, logic bv, logic ae, logic ld, logic pe);
    result_t r;
    r.out_byte    = bv ? b : 8'h00;
    r.byte_valid  = bv;
    r.arg_end     = ae;
    r.line_done   = ld;
    r.parse_error = pe;
    r.arg_count   = arg_total;
    r.last        = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    add_result(b, 1'b1, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic void close_arg();
    if (arg_total != COUNT_MAX) arg_total++;
    add_result(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    tok_mode = MODE_IDLE;
  endfunction

  function automatic void close_line(logic err);
    add_result(8'h00, 1'b0, 1'b0, 1'b1, err);
    arg_total = 8'h00;
    tok_mode  = MODE_IDLE;
  endfunction

  // an error at the line end closes the line; elsewhere the rest of the line is dropped
  function automatic void fail_on(logic [7:0] c);
    if (c == CH_NUL) begin
      close_line(1'b1);
    end else begin
      add_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      tok_mode = MODE_DISCARD;
    end
  endfunction

  function automatic void dq_step(logic [7:0] c);
    if (c == CH_BSLASH) tok_mode = MODE_DQ_ESC;
    else if (c == CH_DQUOTE) tok_mode = MODE_CLOSE;
    else if (c == CH_NUL) fail_on(c);
    else begin
      add_byte(c);
      tok_mode = MODE_DQ;
    end
  endfunction

  function automatic void sq_step(logic [7:0] c);
    if (c == CH_BSLASH) tok_mode = MODE_SQ_ESC;
    else if (c == CH_SQUOTE) tok_mode = MODE_CLOSE;
    else if (c == CH_NUL) fail_on(c);
    else begin
      add_byte(c);
      tok_mode = MODE_SQ;
    end
  endfunction

  // vertical tab and form feed are argument bytes here
  function automatic void unq_step(logic [7:0] c);
    if (c == CH_NUL) begin
      close_arg();
      close_line(1'b0);
    end else if (c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB) close_arg();
    else if (c == CH_DQUOTE) tok_mode = MODE_DQ;
    else if (c == CH_SQUOTE) tok_mode = MODE_SQ;
    else begin
      add_byte(c);
      tok_mode = MODE_UNQ;
    end
  endfunction

  // leaves the items caused by one character in step_q
  function automatic void predict_char(logic [7:0] c);
    result_t r;
    step_q.delete();
    case (tok_mode)
      MODE_UNQ: unq_step(c);
      MODE_DQ:  dq_step(c);
      MODE_DQ_ESC: begin
        if (c == CH_LX) tok_mode = MODE_DQ_X;
        else if (c == CH_NUL) begin
          // dangling backslash is kept, then the open quote fails
          add_byte(CH_BSLASH);
          close_line(1'b1);
        end else begin
          add_byte(esc_byte(c));
          tok_mode = MODE_DQ;
        end
      end
      MODE_DQ_X: begin
        if (is_hexdig(c)) begin
          hex_first = c;
          tok_mode  = MODE_DQ_XH;
        end else begin
          add_byte(CH_LX);
          dq_step(c);
        end
      end
      MODE_DQ_XH: begin
        if (is_hexdig(c)) begin
          add_byte({hex_nibble(hex_first), hex_nibble(c)});
          tok_mode = MODE_DQ;
        end else begin
          // short hex escape: the x and the digit come out as plain bytes
          add_byte(CH_LX);
          add_byte(hex_first);
          dq_step(c);
        end
      end
      MODE_SQ: sq_step(c);
      MODE_SQ_ESC: begin
        if (c == CH_SQUOTE) begin
          add_byte(CH_SQUOTE);
          tok_mode = MODE_SQ;
        end else begin
          add_byte(CH_BSLASH);
          sq_step(c);
        end
      end
      MODE_CLOSE: begin
        if (c == CH_NUL) begin
          close_arg();
          close_line(1'b0);
        end else if (is_space(c)) close_arg();
        else fail_on(c);
      end
      MODE_DISCARD: if (c == CH_NUL) close_line(1'b1);
      default: begin
        if (c == CH_NUL) close_line(1'b0);
        else if (!is_space(c)) unq_step(c);
        else tok_mode = MODE_IDLE;
      end
    endcase
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic result_t mk_res(logic [7:0] b, logic bv, logic ae, logic ld, logic pe,
                                     logic [7:0] cnt);
    return '{out_byte: b, byte_valid: bv, arg_end: ae, line_done: ld, parse_error: pe,
             arg_count: cnt, last: 1'b1};
  endfunction

  function automatic dir_row_t typed_row(logic [7:0] c, result_t r);
    return '{ch: c, typed: 1'b1, res: r};
  endfunction

  function automatic dir_row_t pred_row(logic [7:0] c);
    return '{ch: c, typed: 1'b0, res: '0};
  endfunction

  // byte of an unquoted part: no separator, no quote, no line end
  function automatic logic [7:0] pick_unq_byte();
    logic [7:0] c;
    do begin
      case ($urandom_range(0, 9))
        0:       c = 8'($urandom_range(128, 255));
        1:       c = 8'($urandom_range(1, 31));
        default: c = 8'($urandom_range(33, 126));
      endcase
    end while (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR
               || c == CH_DQUOTE || c == CH_SQUOTE);
    return c;
  endfunction

  // plain byte inside a quoted part
  function automatic logic [7:0] pick_quoted_byte(logic [7:0] q);
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(1, 255));
      else c = 8'($urandom_range(32, 126));
    end while (c == q || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] pick_hexdig();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return CH_DIG0 + 8'(v);
    if (v < 16) return CH_LA + 8'(v - 10);
    return CH_UPA + 8'(v - 16);
  endfunction

  // after unquoted bytes only space, tab, newline or return ends the argument
  function automatic logic [7:0] pick_space(bit any);
    case ($urandom_range(0, any ? 5 : 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_CR;
      4:       return CH_VT;
      default: return CH_FFEED;
    endcase
  endfunction

  function automatic void add_dq_piece();
    int kind;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 40) line_q.push_back(pick_quoted_byte(CH_DQUOTE));
    else if (kind < 55) begin
      line_q.push_back(CH_BSLASH);
      case ($urandom_range(0, 4))
        0:       line_q.push_back(CH_LA);
        1:       line_q.push_back(CH_LB);
        2:       line_q.push_back(CH_LN);
        3:       line_q.push_back(CH_LR);
        default: line_q.push_back(CH_LT);
      endcase
    end else if (kind < 70) begin
      line_q.push_back(CH_BSLASH);
      line_q.push_back(CH_LX);
      line_q.push_back(pick_hexdig());
      line_q.push_back(pick_hexdig());
    end else if (kind < 80) begin
      // hex escape cut short by a non-digit
      line_q.push_back(CH_BSLASH);
      line_q.push_back(CH_LX);
      if ($urandom_range(0, 1) == 1) line_q.push_back(pick_hexdig());
      do c = pick_quoted_byte(CH_DQUOTE); while (is_hexdig(c));
      line_q.push_back(c);
    end else begin
      // any escaped byte other than x; it stands for itself unless it is a, b, n, r or t
      do c = 8'($urandom_range(1, 255)); while (c == CH_LX);
      line_q.push_back(CH_BSLASH);
      line_q.push_back(c);
    end
  endfunction

  function automatic void add_sq_piece();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 60) line_q.push_back(pick_quoted_byte(CH_SQUOTE));
    else if (kind < 80) begin
      line_q.push_back(CH_BSLASH);
      line_q.push_back(CH_SQUOTE);
    end else begin
      line_q.push_back(CH_BSLASH);
      line_q.push_back(pick_quoted_byte(CH_SQUOTE));
    end
  endfunction

  // one random line ending in a zero byte: mostly well formed, some with a bad closing quote
  // or an unterminated quote, some plain noise
  function automatic void build_line();
    int flaw, nargs, k, n;
    bit line_over, quoted, dq;
    logic [7:0] q;
    line_q.delete();
    flaw = $urandom_range(0, 99);
    if (flaw >= 90) begin
      n = $urandom_range(1, 16);
      repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(CH_NUL);
      return;
    end
    flaw = (flaw < 75) ? 0 : ((flaw < 83) ? 1 : 2);
    nargs = $urandom_range(0, 5);
    line_over = 1'b0;
    repeat ($urandom_range(0, 2)) line_q.push_back(pick_space(1'b1));
    for (k = 0; k < nargs && !line_over; k++) begin
      n = $urandom_range(0, 4);
      quoted = (n == 0) || ($urandom_range(0, 1) == 1);
      repeat (n) line_q.push_back(pick_unq_byte());
      if (quoted) begin
        dq = 1'($urandom_range(0, 1));
        q = dq ? CH_DQUOTE : CH_SQUOTE;
        line_q.push_back(q);
        repeat ($urandom_range(0, 5)) begin
          if (dq) add_dq_piece();
          else add_sq_piece();
        end
        if (flaw == 2) begin
          line_q.push_back(CH_NUL);
          line_over = 1'b1;
        end else begin
          line_q.push_back(q);
          if (flaw == 1) begin
            // junk right after the closing quote
            line_q.push_back(8'($urandom_range(33, 126)));
            flaw = 0;
          end
        end
      end
      if (!line_over && (k < nargs - 1 || $urandom_range(0, 1) == 1)) begin
        line_q.push_back(pick_space(1'b0));
        repeat ($urandom_range(0, 2)) line_q.push_back(pick_space(1'b1));
      end
    end
    if (!line_over) line_q.push_back(CH_NUL);
  endfunction

  // called at a falling edge, returns at the falling edge after the handshake; s_tvalid stays
  // high so back-to-back items keep it up without a dip
  task automatic send_char(input logic [7:0] c, input logic typed, input result_t want);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= c;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_char(c);
    if (typed) begin
      step_q.delete();
      step_q.push_back(want);
    end
    foreach (step_q[k]) pending_q.push_back(step_q[k]);
    @(negedge clk);
  endtask

  // drop valid and wait until the block owes nothing
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------------------------

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  initial begin : result_check
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          $error("result item with nothing expected: tdata %h tuser %h tlast %b",
                 m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = pending_q.pop_front();
          cmp_field("out_byte",    want.out_byte,    m_tdata[7:0]);
          cmp_field("arg_count",   want.arg_count,   m_tdata[15:8]);
          cmp_field("byte_valid",  want.byte_valid,  m_tuser[0]);
          cmp_field("arg_end",     want.arg_end,     m_tuser[1]);
          cmp_field("line_done",   want.line_done,   m_tuser[2]);
          cmp_field("parse_error", want.parse_error, m_tuser[3]);
          cmp_field("last_of_run", want.last,        m_tlast);
        end
      end
    end
  end

  // receiver: phases of steady ready, light and heavy stalling, plus one long hold-off that
  // lets the bundle queue fill while characters keep coming
  initial begin : result_ready
    int stall_left;
    int hold_left;
    int phase_left;
    int stall_pct;
    bit hold_done;
    stall_left = 0;
    hold_left  = 0;
    phase_left = 0;
    stall_pct  = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 45;
        endcase
      end
      phase_left--;
      if (!hold_done && results_seen >= 60) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------------------------

  initial begin : stimulus
    int rand_sent;
    rand_sent = 0;

    // directed lines:
    //   empty line; byte 0xff, backslash and vertical tab as unquoted bytes; a double quote
    //   opened mid-argument with a short hex escape and a \n; form feed after the close;
    //   a single quote with a non-quote escape, then junk after the close (bad close), a
    //   discarded byte and the line end; whitespace-only line; open quote with a backslash
    //   right before the line end
    dir_tab = '{
      typed_row(CH_NUL,    mk_res(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0)),
      typed_row(CH_TOP,    mk_res(CH_TOP, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0)),
      pred_row(CH_BSLASH),
      pred_row(CH_VT),
      pred_row(CH_DQUOTE),
      pred_row(CH_BSLASH),
      pred_row(CH_LX),
      pred_row("4"),
      pred_row("g"),
      pred_row(CH_BSLASH),
      pred_row(CH_LN),
      pred_row(CH_DQUOTE),
      pred_row(CH_FFEED),
      pred_row(CH_SQUOTE),
      pred_row(CH_BSLASH),
      pred_row("q"),
      pred_row(CH_SQUOTE),
      typed_row("z",       mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 8'd1)),
      pred_row("w"),
      typed_row(CH_NUL,    mk_res(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'd1)),
      pred_row(CH_SPACE),
      typed_row(CH_NUL,    mk_res(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0)),
      pred_row(CH_DQUOTE),
      pred_row(CH_BSLASH),
      pred_row(CH_NUL)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    foreach (dir_tab[k]) send_char(dir_tab[k].ch, dir_tab[k].typed, dir_tab[k].res);

    // sender pauses until every owed item is out
    drain();

    while (rand_sent < RAND_ITEMS) begin
      build_line();
      case ($urandom_range(0, 3))
        0, 1:    send_idle_pct = 0;
        2:       send_idle_pct = 15;
        default: send_idle_pct = 50;
      endcase
      foreach (line_q[k]) send_char(line_q[k], 1'b0, '0);
      rand_sent += line_q.size();
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/qatu_pkg.sv
rtl/qatu_front.sv
rtl/qatu_queue.sv
rtl/qatu_back.sv
rtl/quoted_argument_tokenizer_unit.sv
test/quoted_argument_tokenizer_unit_test.sv
